/* hdl/bcte_pkg.sv */
// Shared types and codes for the block chain table engine.
`timescale 1ns / 1ps

package bcte_pkg;

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_RESIZE = 2'd1,
        MODE_FREE   = 2'd2,
        MODE_LOCATE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_SHORT = 2'd2
    } status_t;

    // Tag held in the top two bits of each link table entry
    typedef enum logic [1:0] {
        TAG_LINK = 2'd0,
        TAG_END  = 2'd1,
        TAG_FREE = 2'd2
    } tag_t;

    // Datapath micro-operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE     = 5'd0,
        OP_CLEAR    = 5'd1,
        OP_LOAD     = 5'd2,
        OP_DIV      = 5'd3,
        OP_SHORT    = 5'd4,
        OP_WALK     = 5'd5,
        OP_NX_CHK   = 5'd6,
        OP_SCAN_RD  = 5'd7,
        OP_SCAN_CHK = 5'd8,
        OP_CREATE   = 5'd9,
        OP_NOFREE   = 5'd10,
        OP_EXT_LINK = 5'd11,
        OP_EXT_END  = 5'd12,
        OP_TAIL     = 5'd13,
        OP_FR_RD    = 5'd14,
        OP_FR_W     = 5'd15,
        OP_RZ_END   = 5'd16,
        OP_LOC      = 5'd17,
        OP_DONE     = 5'd18
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic  div_done;
        logic  start_live;
        logic  cur_next_ok;
        logic  fb_next_ok;
        logic  rd_free;
        logic  steps_zero;
        logic  scan_end;
        logic  cnt_last;
        logic  out_free;
        mode_t mode;
    } sts_t;

endpackage

/* hdl/bcte_div.sv */
// Reciprocal-multiply divider by a constant block size; the quotient is registered first, then the remainder.
`timescale 1ns / 1ps

module bcte_div #(
    parameter int DIVISOR = 420
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    output logic        done,
    output logic [15:0] quotient,
    output logic [8:0]  remainder
);

    // floor(x / DIVISOR) = (x * RECIP) >> SHIFT, exact for every 16-bit x
    localparam int              SHIFT   = 16 + $clog2(DIVISOR);
    localparam longint unsigned RECIP   =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam int              MW      = $clog2(RECIP + 64'd1);
    localparam int              PW      = 16 + MW;
    localparam logic [MW-1:0]   RECIP_C = MW'(RECIP);
    localparam logic [15:0]     DIV_C   = 16'(DIVISOR);

    logic          busy_reg, busy_next;
    logic          step_reg, step_next;
    logic [15:0]   x_reg, x_next;
    logic [15:0]   q_reg, q_next;
    logic [15:0]   r_reg, r_next;
    logic [PW-1:0] prod;
    logic [15:0]   back;

    assign prod = {{MW{1'b0}}, x_reg} * {16'd0, RECIP_C};
    assign back = q_reg * DIV_C;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        x_next    = x_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 1'b0;
            x_next    = dividend;
        end
        else if (busy_reg)
        begin
            if (!step_reg)
            begin
                q_next    = 16'(prod >> SHIFT);
                step_next = 1'b1;
            end
            else
            begin
                r_next    = x_reg - back;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign done      = !busy_reg;
    assign quotient  = q_reg;
    assign remainder = 9'(r_reg);

endmodule

/* hdl/bcte_dp.sv */
// Datapath: link table memory, walk and scan pointers, result registers.
`timescale 1ns / 1ps

module bcte_dp #(
    parameter int NUM_BLOCKS  = 128,
    parameter int BLOCK_BYTES = 420
) (
    input  logic           clk,
    input  logic           rst_n,
    input  bcte_pkg::cmd_t cmd,
    output bcte_pkg::sts_t sts,
    input  logic [1:0]     in_mode,
    input  logic [6:0]     in_first,
    input  logic [15:0]    in_bytes,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [6:0]     out_block,
    output logic [8:0]     out_offset,
    output logic [1:0]     out_status
);
    import bcte_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int EW = AW + 2;

    localparam logic [EW-1:0] ENT_FREE = {TAG_FREE, {AW{1'b0}}};
    localparam logic [EW-1:0] ENT_END  = {TAG_END, {AW{1'b0}}};

    // link table
    logic [EW-1:0] mem [NUM_BLOCKS];
    logic [EW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    // divider
    logic        div_done;
    logic [15:0] quot;
    logic [8:0]  rem;

    bcte_div #(
        .DIVISOR (BLOCK_BYTES)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.op == OP_LOAD),
        .dividend  (in_bytes),
        .done      (div_done),
        .quotient  (quot),
        .remainder (rem)
    );

    // control registers
    logic [CW-1:0] hint_reg, hint_next;   // every entry below hint is in use
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    mode_t         mode_reg, mode_next;
    logic [6:0]    start_reg, start_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [EW-1:0] cur_ent_reg, cur_ent_next;
    logic [AW-1:0] fb_reg, fb_next;
    logic [EW-1:0] fb_ent_reg, fb_ent_next;
    logic [15:0]   steps_reg, steps_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [6:0]    blk_reg, blk_next;
    logic [8:0]    off_reg, off_next;
    status_t       st_reg, st_next;
    logic [6:0]    out_blk_reg, out_blk_next;
    logic [8:0]    out_off_reg, out_off_next;
    status_t       out_st_reg, out_st_next;

    logic [AW-1:0] cur_idx, fb_idx;
    logic          cur_link, fb_link, rd_free;

    assign cur_idx  = cur_ent_reg[AW-1:0];
    assign fb_idx   = fb_ent_reg[AW-1:0];
    assign cur_link = (cur_ent_reg[EW-1:EW-2] == TAG_LINK);
    assign fb_link  = (fb_ent_reg[EW-1:EW-2] == TAG_LINK);
    assign rd_free  = (rdata_reg[EW-1:EW-2] == TAG_FREE);

    always_comb
    begin
        sts.div_done    = div_done;
        sts.start_live  = (32'(start_reg) < NUM_BLOCKS) && !rd_free;
        sts.cur_next_ok = cur_link && !rd_free;
        sts.fb_next_ok  = fb_link && !rd_free;
        sts.rd_free     = rd_free;
        sts.steps_zero  = (steps_reg == 16'd0);
        sts.scan_end    = (scan_reg >= CW'(NUM_BLOCKS));
        sts.cnt_last    = (cnt_reg == CW'(NUM_BLOCKS - 1));
        sts.out_free    = !out_valid_reg || out_ready;
        sts.mode        = mode_reg;
    end

    always_comb
    begin
        hint_next      = hint_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mode_next      = mode_reg;
        start_next     = start_reg;
        cur_next       = cur_reg;
        cur_ent_next   = cur_ent_reg;
        fb_next        = fb_reg;
        fb_ent_next    = fb_ent_reg;
        steps_next     = steps_reg;
        scan_next      = scan_reg;
        blk_next       = blk_reg;
        off_next       = off_reg;
        st_next        = st_reg;
        out_blk_next   = out_blk_reg;
        out_off_next   = out_off_reg;
        out_st_next    = out_st_reg;
        mem_we         = 1'b0;
        mem_wa         = cur_reg;
        mem_wd         = ENT_END;
        mem_ra         = cur_idx;

        case (cmd.op)
            OP_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wa    = cnt_reg[AW-1:0];
                mem_wd    = ENT_FREE;
                hint_next = '0;
                cnt_next  = sts.cnt_last ? '0 : (cnt_reg + CW'(1));
            end
            OP_LOAD:
            begin
                mode_next  = mode_t'(in_mode);
                start_next = in_first;
                blk_next   = in_first;
                off_next   = '0;
                st_next    = ST_OK;
                scan_next  = hint_reg;
                cnt_next   = '0;
            end
            OP_DIV:
            begin
                // start entry is re-read every cycle until the quotient settles
                mem_ra      = AW'(start_reg);
                steps_next  = quot;
                cur_next    = AW'(start_reg);
                cur_ent_next = rdata_reg;
                fb_next     = AW'(start_reg);
                fb_ent_next = rdata_reg;
            end
            OP_SHORT:
            begin
                st_next = ST_SHORT;
            end
            OP_WALK:
            begin
                mem_ra = cur_idx;
            end
            OP_NX_CHK:
            begin
                if (sts.cur_next_ok)
                begin
                    cur_next     = cur_idx;
                    cur_ent_next = rdata_reg;
                    steps_next   = steps_reg - 16'd1;
                end
                else
                begin
                    scan_next = hint_reg;
                end
            end
            OP_SCAN_RD:
            begin
                mem_ra = scan_reg[AW-1:0];
            end
            OP_SCAN_CHK:
            begin
                if (!rd_free)
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            OP_CREATE:
            begin
                mem_we    = 1'b1;
                mem_wa    = scan_reg[AW-1:0];
                mem_wd    = ENT_END;
                blk_next  = 7'(scan_reg);
                hint_next = scan_reg + CW'(1);
            end
            OP_NOFREE:
            begin
                st_next   = ST_FULL;
                hint_next = CW'(NUM_BLOCKS);
                if (mode_reg == MODE_CREATE)
                begin
                    blk_next = '0;
                end
            end
            OP_EXT_LINK:
            begin
                mem_we    = 1'b1;
                mem_wa    = cur_reg;
                mem_wd    = {TAG_LINK, scan_reg[AW-1:0]};
                hint_next = scan_reg + CW'(1);
            end
            OP_EXT_END:
            begin
                mem_we       = 1'b1;
                mem_wa       = scan_reg[AW-1:0];
                mem_wd       = ENT_END;
                cur_next     = scan_reg[AW-1:0];
                cur_ent_next = ENT_END;
                steps_next   = steps_reg - 16'd1;
            end
            OP_TAIL:
            begin
                if (sts.cur_next_ok)
                begin
                    fb_next     = cur_idx;
                    fb_ent_next = rdata_reg;
                end
            end
            OP_FR_RD:
            begin
                mem_ra = fb_idx;
            end
            OP_FR_W:
            begin
                mem_we   = 1'b1;
                mem_wa   = fb_reg;
                mem_wd   = ENT_FREE;
                cnt_next = cnt_reg + CW'(1);
                if (CW'(fb_reg) < hint_reg)
                begin
                    hint_next = CW'(fb_reg);
                end
                if (sts.fb_next_ok)
                begin
                    fb_next = fb_idx;
                    // a self link was read before this block was freed
                    fb_ent_next = (fb_idx == fb_reg) ? ENT_FREE : rdata_reg;
                end
            end
            OP_RZ_END:
            begin
                mem_we = 1'b1;
                mem_wa = cur_reg;
                mem_wd = ENT_END;
            end
            OP_LOC:
            begin
                blk_next = 7'(cur_reg);
                off_next = rem;
            end
            OP_DONE:
            begin
                out_valid_next = 1'b1;
                out_blk_next   = blk_reg;
                out_off_next   = off_reg;
                out_st_next    = st_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hint_reg      <= hint_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        start_reg   <= start_next;
        cur_reg     <= cur_next;
        cur_ent_reg <= cur_ent_next;
        fb_reg      <= fb_next;
        fb_ent_reg  <= fb_ent_next;
        steps_reg   <= steps_next;
        scan_reg    <= scan_next;
        blk_reg     <= blk_next;
        off_reg     <= off_next;
        st_reg      <= st_next;
        out_blk_reg <= out_blk_next;
        out_off_reg <= out_off_next;
        out_st_reg  <= out_st_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_block  = out_blk_reg;
    assign out_offset = out_off_reg;
    assign out_status = out_st_reg;

endmodule

/* hdl/bcte_ctrl.sv */
// Controller state machine sequencing the chain table operations.
`timescale 1ns / 1ps

module bcte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output bcte_pkg::cmd_t cmd,
    input  bcte_pkg::sts_t sts
);
    import bcte_pkg::*;

    typedef enum logic [17:0] {
        S_CLEAR    = 18'h00001,
        S_IDLE     = 18'h00002,
        S_DIV      = 18'h00004,
        S_SHORT    = 18'h00008,
        S_WALK     = 18'h00010,
        S_NX_CHK   = 18'h00020,
        S_SCAN_RD  = 18'h00040,
        S_SCAN_CHK = 18'h00080,
        S_CREATE   = 18'h00100,
        S_NOFREE   = 18'h00200,
        S_EXT_LINK = 18'h00400,
        S_EXT_END  = 18'h00800,
        S_TAIL     = 18'h01000,
        S_FR_RD    = 18'h02000,
        S_FR_W     = 18'h04000,
        S_RZ_END   = 18'h08000,
        S_LOC      = 18'h10000,
        S_DONE     = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (sts.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (sts.div_done)
                begin
                    if (sts.mode == MODE_CREATE)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (!sts.start_live)
                    begin
                        state_next = S_SHORT;
                    end
                    else if (sts.mode == MODE_FREE)
                    begin
                        state_next = S_FR_RD;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_SHORT:
            begin
                cmd.op     = OP_SHORT;
                state_next = S_DONE;
            end
            S_WALK:
            begin
                cmd.op = OP_WALK;
                if (!sts.steps_zero)
                begin
                    state_next = S_NX_CHK;
                end
                else if (sts.mode == MODE_LOCATE)
                begin
                    state_next = S_LOC;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_NX_CHK:
            begin
                cmd.op = OP_NX_CHK;
                if (sts.cur_next_ok)
                begin
                    state_next = S_WALK;
                end
                else if (sts.mode == MODE_LOCATE)
                begin
                    state_next = S_SHORT;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.op     = OP_SCAN_RD;
                state_next = sts.scan_end ? S_NOFREE : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                cmd.op = OP_SCAN_CHK;
                if (!sts.rd_free)
                begin
                    state_next = S_SCAN_RD;
                end
                else if (sts.mode == MODE_CREATE)
                begin
                    state_next = S_CREATE;
                end
                else
                begin
                    state_next = S_EXT_LINK;
                end
            end
            S_CREATE:
            begin
                cmd.op     = OP_CREATE;
                state_next = S_DONE;
            end
            S_NOFREE:
            begin
                cmd.op     = OP_NOFREE;
                state_next = (sts.mode == MODE_CREATE) ? S_DONE : S_RZ_END;
            end
            S_EXT_LINK:
            begin
                cmd.op     = OP_EXT_LINK;
                state_next = S_EXT_END;
            end
            S_EXT_END:
            begin
                cmd.op     = OP_EXT_END;
                state_next = S_WALK;
            end
            S_TAIL:
            begin
                cmd.op     = OP_TAIL;
                state_next = sts.cur_next_ok ? S_FR_RD : S_RZ_END;
            end
            S_FR_RD:
            begin
                cmd.op     = OP_FR_RD;
                state_next = S_FR_W;
            end
            S_FR_W:
            begin
                cmd.op = OP_FR_W;
                if (sts.fb_next_ok && !sts.cnt_last)
                begin
                    state_next = S_FR_RD;
                end
                else if (sts.mode == MODE_RESIZE)
                begin
                    state_next = S_RZ_END;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RZ_END:
            begin
                cmd.op     = OP_RZ_END;
                state_next = S_DONE;
            end
            S_LOC:
            begin
                cmd.op     = OP_LOC;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/block_chain_table_engine.sv */
// Top level of the block chain table engine.
`timescale 1ns / 1ps

// Keeps a link table of NUM_BLOCKS entries (free, end of chain, or next block)
// and runs one command per input beat, giving exactly one result beat.
// Input beat: s_axis_tuser = mode (create, resize, free, locate);
// s_axis_tdata = first block and byte count. Output beat: m_axis_tdata =
// block index and byte offset; m_axis_tuser = status.
// After reset the table is swept to all-free, one entry per cycle, while
// s_axis_tready stays low.
// One command is processed at a time. After the accept cycle the byte count
// is divided by BLOCK_BYTES; then chain links are walked, table entries are
// scanned for a free block, blocks are added and blocks are freed, and the
// command finishes with its result. The registered read of the link table
// memory splits each walk, scan and free step into a read and a check state.
// Free-block scans resume from the lowest possibly free entry, so one resize
// scans each entry at most once.
// The result sits in an output register; a stalled receiver holds it while
// the next command is accepted and worked on, and that command waits at its
// end until the register is taken.
module block_chain_table_engine #(
    parameter int NUM_BLOCKS  = 128,
    parameter int BLOCK_BYTES = 420
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // first_block[6:0], byte_count[22:7], zero pad
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // block_index[6:0], byte_offset[15:7]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import bcte_pkg::*;

    cmd_t       cmd;
    sts_t       sts;
    logic [6:0] out_block;
    logic [8:0] out_offset;

    bcte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bcte_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_mode    (s_axis_tuser),
        .in_first   (s_axis_tdata[6:0]),
        .in_bytes   (s_axis_tdata[22:7]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_block  (out_block),
        .out_offset (out_offset),
        .out_status (m_axis_tuser)
    );

    assign m_axis_tdata = {out_offset, out_block};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a command is in progress");

    a_load_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> (s_axis_tvalid && s_axis_tready))
        else $error("command load without an input beat");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.op == OP_DONE))
        else $error("result beat raised outside the done step");

    a_done_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DONE) |-> sts.out_free)
        else $error("result loaded over an untaken beat");

    a_no_input_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CLEAR) |-> !s_axis_tready)
        else $error("input ready during the table sweep");

endmodule

/* test/block_chain_table_engine_tb.sv */
// Self-checking stream testbench for the block chain table engine.
`timescale 1ns / 1ps

module block_chain_table_engine_tb;

    import bcte_pkg::*;

    localparam int NUM_BLOCKS  = 128;
    localparam int BLOCK_BYTES = 420;
    localparam int LINK_FREE   = -1;
    localparam int LINK_END    = -2;
    localparam int RANDOM_CMDS = 1525;
    localparam int CALM_TAIL   = 150;
    localparam int DRAIN_CYCLES = 1200;

    typedef struct packed {
        mode_t       mode;
        logic [6:0]  first_block;
        logic [15:0] byte_count;
    } chain_cmd_t;

    typedef struct packed {
        logic [6:0] block_index;
        logic [8:0] byte_offset;
        status_t    status;
    } chain_res_t;

    typedef struct packed {
        chain_cmd_t cmd;
        chain_res_t res;
    } queued_cmd_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // first_block[6:0], byte_count[22:7], zero pad
    logic [1:0]  s_axis_tuser = '0;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // block_index[6:0], byte_offset[15:7]
    logic [1:0]  m_axis_tuser;        // status[1:0]

    // Shadow link table: next index, LINK_END or LINK_FREE
    int          link_shadow [NUM_BLOCKS];
    int          chain_heads [$];
    queued_cmd_t pending_cmds [$];
    chain_res_t  expected_results [$];
    chain_res_t  presented_res;
    int          total_cmds = 0;
    int          issued_cmds = 0;
    int          seen_results = 0;
    int          mismatches = 0;
    int          send_gap = 0;
    int          recv_stall = 0;

    block_chain_table_engine #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    function automatic bit block_live(int b);
        return b >= 0 && b < NUM_BLOCKS && link_shadow[b] != LINK_FREE;
    endfunction

    // Dangling links (to free entries) count as chain end
    function automatic int next_link(int b);
        int n;
        if (b < 0 || b >= NUM_BLOCKS)
            return -1;
        n = link_shadow[b];
        if (n < 0 || n >= NUM_BLOCKS || link_shadow[n] == LINK_FREE)
            return -1;
        return n;
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < NUM_BLOCKS; i++)
            if (link_shadow[i] == LINK_FREE)
                return i;
        return -1;
    endfunction

    function automatic void release_chain(int b);
        int count;
        int n;
        count = 0;
        while (b >= 0 && count < NUM_BLOCKS) begin
            n = next_link(b);
            link_shadow[b] = LINK_FREE;
            b = n;
            count++;
        end
    endfunction

    // Runs one command on the shadow table and returns its result beat
    function automatic chain_res_t apply_command(chain_cmd_t c);
        chain_res_t r;
        int start;
        int steps;
        int cur;
        int n;
        int f;
        bit stopped;
        start = int'(c.first_block);
        r.block_index = c.first_block;
        r.byte_offset = '0;
        r.status = ST_OK;
        steps = int'(c.byte_count) / BLOCK_BYTES;
        cur = start;
        stopped = 1'b0;
        if (c.mode == MODE_CREATE) begin
            f = lowest_free();
            if (f < 0) begin
                r.block_index = '0;
                r.status = ST_FULL;
            end
            else begin
                link_shadow[f] = LINK_END;
                r.block_index = f[6:0];
            end
        end
        else if (!block_live(start)) begin
            r.status = ST_SHORT;
        end
        else if (c.mode == MODE_RESIZE) begin
            while (steps > 0) begin
                n = next_link(cur);
                if (n < 0) begin
                    f = lowest_free();
                    if (f < 0) begin
                        stopped = 1'b1;
                        break;
                    end
                    link_shadow[cur] = f;
                    link_shadow[f] = LINK_END;
                    n = f;
                end
                cur = n;
                steps--;
            end
            if (stopped)
                r.status = ST_FULL;
            else
                release_chain(next_link(cur));
            link_shadow[cur] = LINK_END;
        end
        else if (c.mode == MODE_FREE) begin
            release_chain(start);
        end
        else begin
            while (steps > 0) begin
                n = next_link(cur);
                if (n < 0) begin
                    stopped = 1'b1;
                    break;
                end
                cur = n;
                steps--;
            end
            if (stopped) begin
                r.status = ST_SHORT;
            end
            else begin
                r.block_index = cur[6:0];
                r.byte_offset = 9'(int'(c.byte_count) % BLOCK_BYTES);
            end
        end
        return r;
    endfunction

    function automatic void queue_cmd(mode_t mode, int first_block, int byte_count);
        queued_cmd_t q;
        q.cmd.mode = mode;
        q.cmd.first_block = first_block[6:0];
        q.cmd.byte_count = byte_count[15:0];
        q.res = apply_command(q.cmd);
        if (mode == MODE_CREATE && q.res.status == ST_OK)
            chain_heads.push_back(int'(q.res.block_index));
        pending_cmds.push_back(q);
    endfunction

    function automatic int pick_head();
        int idx;
        while (chain_heads.size() > 0) begin
            idx = $urandom_range(0, chain_heads.size() - 1);
            if (block_live(chain_heads[idx]))
                return chain_heads[idx];
            chain_heads.delete(idx);
        end
        return -1;
    endfunction

    function automatic int small_size();
        if ($urandom_range(0, 29) == 0)
            return $urandom_range(0, 16'hFFFF);
        return $urandom_range(0, BLOCK_BYTES * 5);
    endfunction

    // Input side: present queued commands, random gaps between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(presented_res);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    queued_cmd_t q;
                    q = pending_cmds.pop_front();
                    presented_res = q.res;
                    s_axis_tdata  <= {1'b0, q.cmd.byte_count, q.cmd.first_block};
                    s_axis_tuser  <= q.cmd.mode;
                    s_axis_tvalid <= 1'b1;
                    issued_cmds++;
                    if (pending_cmds.size() > CALM_TAIL && (issued_cmds / 80) % 4 != 3
                        && $urandom_range(0, 6) == 0)
                        send_gap = $urandom_range(1, 18);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random stall bursts, compare each result beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                chain_res_t want;
                seen_results++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat tdata=%h tuser=%h",
                                 $realtime, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[6:0] !== want.block_index
                        || m_axis_tdata[15:7] !== want.byte_offset
                        || m_axis_tuser !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result %0d want blk/off/st %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, seen_results, want.block_index,
                                     want.byte_offset, want.status, m_axis_tdata[6:0],
                                     m_axis_tdata[15:7], m_axis_tuser);
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (seen_results + CALM_TAIL < total_cmds && (seen_results / 70) % 4 != 1
                     && $urandom_range(0, 9) == 0)
            begin
                recv_stall = $urandom_range(0, 17);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int head;
        int pick;
        for (int i = 0; i < NUM_BLOCKS; i++)
            link_shadow[i] = LINK_FREE;

        // Directed: bad starts, basic chains, dangling link, full table, walk bound
        queue_cmd(MODE_LOCATE, 0, 0);
        queue_cmd(MODE_RESIZE, 127, 16'hFFFF);
        queue_cmd(MODE_FREE, 5, 0);
        queue_cmd(MODE_CREATE, 127, 16'hFFFF);
        queue_cmd(MODE_CREATE, 0, 0);
        queue_cmd(MODE_RESIZE, 0, 0);
        queue_cmd(MODE_RESIZE, 0, BLOCK_BYTES * 3 + 5);
        queue_cmd(MODE_LOCATE, 0, BLOCK_BYTES * 3 + 419);
        queue_cmd(MODE_LOCATE, 0, BLOCK_BYTES * 4);
        queue_cmd(MODE_LOCATE, 0, 0);
        queue_cmd(MODE_RESIZE, 0, BLOCK_BYTES);
        queue_cmd(MODE_FREE, 2, 0);
        queue_cmd(MODE_LOCATE, 0, BLOCK_BYTES);
        queue_cmd(MODE_RESIZE, 0, BLOCK_BYTES * 2);
        queue_cmd(MODE_FREE, 1, 0);
        queue_cmd(MODE_RESIZE, 0, 16'hFFFF);
        queue_cmd(MODE_CREATE, 0, 0);
        queue_cmd(MODE_LOCATE, 0, 53759);
        queue_cmd(MODE_LOCATE, 0, 16'hFFFF);
        queue_cmd(MODE_RESIZE, 0, 53759);
        queue_cmd(MODE_FREE, 0, 0);
        queue_cmd(MODE_LOCATE, 0, 0);

        // Random: mostly commands on live chains, some noise
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            head = pick_head();
            pick = $urandom_range(0, 99);
            if (pick < 5)
                queue_cmd(mode_t'($urandom_range(0, 3)), $urandom_range(0, 127),
                          $urandom_range(0, 16'hFFFF));
            else if (head < 0 || pick < 25 && chain_heads.size() < 20)
                queue_cmd(MODE_CREATE, $urandom_range(0, 127), $urandom_range(0, 16'hFFFF));
            else if (pick < 35 || chain_heads.size() >= 20 && pick < 45)
                queue_cmd(MODE_FREE, head, $urandom_range(0, 16'hFFFF));
            else if (pick < 65)
                queue_cmd(MODE_RESIZE, head, small_size());
            else if (pick < 70)
                queue_cmd(MODE_LOCATE, head, $urandom_range(0, 16'hFFFF));
            else
                queue_cmd(MODE_LOCATE, head, $urandom_range(0, BLOCK_BYTES * 6));
        end
        total_cmds = pending_cmds.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("block_chain_table_engine_tb: PASS");
        else
            $display("block_chain_table_engine_tb: FAIL");
        $finish;
    end

    initial
    begin
        #150_000_000;
        $display("block_chain_table_engine_tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/bcte_pkg.sv
hdl/bcte_div.sv
hdl/bcte_dp.sv
hdl/bcte_ctrl.sv
hdl/block_chain_table_engine.sv
test/block_chain_table_engine_tb.sv
